@@ hw/rtl/pvr_pkg.sv @@
// Package for the polygon vertex rotator: widths, register codes, CORDIC tables.
// Used by polygon_vertex_rotator_top.
package pvr_pkg;
    localparam int MAX_POINTS_DEF   = 32;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 2'd2;

    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    function automatic logic signed [35:0] atan_lookup(input logic [4:0] idx);
        logic signed [35:0] v;
        case (idx)
            5'd0:  v = 36'sh020000000;
            5'd1:  v = 36'sh012E4051E;
            5'd2:  v = 36'sh009FB385B;
            5'd3:  v = 36'sh0051111D4;
            5'd4:  v = 36'sh0028B0D43;
            5'd5:  v = 36'sh00145D7E1;
            5'd6:  v = 36'sh000A2F61E;
            5'd7:  v = 36'sh000517C55;
            5'd8:  v = 36'sh00028BE53;
            5'd9:  v = 36'sh000145F2F;
            5'd10: v = 36'sh0000A2F98;
            5'd11: v = 36'sh0000517CC;
            5'd12: v = 36'sh000028BE6;
            5'd13: v = 36'sh0000145F3;
            5'd14: v = 36'sh00000A2FA;
            5'd15: v = 36'sh00000517D;
            5'd16: v = 36'sh0000028BE;
            5'd17: v = 36'sh00000145F;
            5'd18: v = 36'sh000000A30;
            5'd19: v = 36'sh000000518;
            5'd20: v = 36'sh00000028C;
            5'd21: v = 36'sh000000146;
            5'd22: v = 36'sh0000000A3;
            5'd23: v = 36'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

@@ hw/rtl/polygon_vertex_rotator_top.sv @@
// Polygon vertex rotator: a single CORDIC datapath stepped by a small sequencer.
// After an update transfer, each vertex passes a restoring divide for its angle offset,
// the CORDIC rotation steps, a state of rounding, fold and saturation, and an output state.
// During an update the input is not ready until the last vertex has been taken; a rotate
// is accepted in idle, where it adds its delta to the heading.
// Reset (synchronous, active low) restores register defaults and heading zero.
module polygon_vertex_rotator_top #(
    parameter int MAX_POINTS   = pvr_pkg::MAX_POINTS_DEF,
    parameter int ANGLE_BITS   = pvr_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = pvr_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [pvr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pvr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: heading_delta[15:0], pos_x[31:16], pos_y[47:32]
    input  logic [47:0] s_axis_tdata,
    // tuser: mode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: vertex_x[15:0], vertex_y[31:16], vertex_index[36:32], zero fill
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import pvr_pkg::*;

    localparam int SW  = $clog2(CORDIC_STEPS + 1);
    localparam int DW  = $clog2(ANGLE_BITS + 2);
    localparam int ACC = 36;

    localparam logic [2:0] ST_IDLE = 3'd0, ST_DIV = 3'd1, ST_ITER = 3'd2,
                           ST_FIN = 3'd3, ST_OUT = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_num_points;
    logic [13:0] r_radius;
    logic [ANGLE_BITS-1:0] r_heading;
    logic [5:0]  r_n;
    logic [5:0]  r_vidx;
    logic signed [15:0] r_px, r_py;
    // divide: (i << ANGLE_BITS) / n, one quotient bit a cycle
    logic [5:0]  r_rem;
    logic [ANGLE_BITS+5:0] r_dnum;
    logic [ANGLE_BITS-1:0] r_quo;
    logic [DW-1:0] r_dcnt;
    // CORDIC
    logic signed [ACC-1:0] r_x, r_y, r_z;
    logic [1:0]  r_q;
    logic [SW-1:0] r_step;
    logic signed [15:0] r_ox, r_oy;
    logic [4:0] r_oidx;
    logic r_olast, r_ovalid;

    logic [5:0] n_clamp;
    logic [6:0] rem_sh;
    logic [ANGLE_BITS-1:0] ang;
    logic [31:0] ang32;
    logic signed [ACC-1:0] dx, dy, atn, xr, yr, fx, fy;
    logic signed [19:0] sx, sy;
    logic [43:0] rk;

    // clamp configured point count
    always_comb begin
        n_clamp = r_num_points;
        if (n_clamp < 6'd3) n_clamp = 6'd3;
        if (32'(n_clamp) > MAX_POINTS) n_clamp = 6'(MAX_POINTS);
        if (n_clamp > 6'd32) n_clamp = 6'd32;
    end

    assign rem_sh = {r_rem, r_dnum[ANGLE_BITS+5]};
    assign ang    = r_heading + r_quo;
    assign ang32  = 32'(ang) << (32 - ANGLE_BITS);
    assign rk     = 44'(r_radius) * 44'(GAIN_Q30);
    assign dx     = r_y >>> r_step;
    assign dy     = r_x >>> r_step;
    assign atn    = atan_lookup(5'(r_step));
    assign xr     = (r_x + ACC'(32768)) >>> 16;
    assign yr     = (r_y + ACC'(32768)) >>> 16;

    // quadrant fold and offset
    always_comb begin
        unique case (r_q)
            2'd1:    begin fx = -yr; fy = xr;  end
            2'd2:    begin fx = -xr; fy = -yr; end
            2'd3:    begin fx = yr;  fy = -xr; end
            default: begin fx = xr;  fy = yr;  end
        endcase
        sx = 20'(fx) + 20'(r_px);
        sy = 20'(fy) + 20'(r_py);
    end

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) return 16'sh7FFF;
        if (v < -20'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b0, r_oidx, r_oy, r_ox};
    assign m_axis_tlast  = r_olast;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid && s_axis_tuser) n_state = ST_DIV;
            ST_DIV:  if (r_dcnt == DW'(ANGLE_BITS + 5)) n_state = ST_ITER;
            ST_ITER: if (r_step == SW'(CORDIC_STEPS - 1)) n_state = ST_FIN;
            ST_FIN:  n_state = ST_OUT;
            ST_OUT:  if (m_axis_tready)
                         n_state = (r_olast) ? ST_IDLE : ST_DIV;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer and shared datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_num_points <= 6'd4;
            r_radius     <= 14'd512;
            r_heading    <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_NUM_POINTS:    r_num_points <= i_cfg_data[5:0];
                    REG_RADIUS:        r_radius     <= i_cfg_data[13:0];
                    REG_START_HEADING: r_heading    <= ANGLE_BITS'(i_cfg_data);
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: if (s_axis_tvalid) begin
                    if (!s_axis_tuser)
                        r_heading <= r_heading + ANGLE_BITS'($signed(s_axis_tdata[15:0]));
                    else begin
                        r_n    <= n_clamp;
                        r_px   <= s_axis_tdata[31:16];
                        r_py   <= s_axis_tdata[47:32];
                        r_vidx <= '0;
                        r_rem  <= '0;
                        r_dcnt <= '0;
                        r_dnum <= '0;
                    end
                end
                ST_DIV: begin
                    // restoring divide step
                    if (rem_sh >= 7'(r_n)) begin
                        r_rem <= 6'(rem_sh - 7'(r_n));
                        r_quo <= {r_quo[ANGLE_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[5:0];
                        r_quo <= {r_quo[ANGLE_BITS-2:0], 1'b0};
                    end
                    r_dnum <= r_dnum << 1;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DW'(ANGLE_BITS + 5)) begin
                        r_step <= '0;
                        r_x    <= ACC'(rk >> 14);
                        r_y    <= '0;
                        r_z    <= '0;
                    end
                end
                ST_ITER: begin
                    if (r_step == '0) begin
                        r_q <= ang32[31:30];
                        // first step uses z = low 30 bits of the angle
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= ACC'({ang32[29:0]}) - atn;
                    end else if (!r_z[ACC-1]) begin
                        r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - atn;
                    end else begin
                        r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + atn;
                    end
                    r_step <= r_step + 1'b1;
                end
                ST_FIN: begin
                    r_ox     <= sat16(sx);
                    r_oy     <= sat16(sy);
                    r_oidx   <= r_vidx[4:0];
                    r_olast  <= (r_vidx + 6'd1 == r_n);
                    r_ovalid <= 1'b1;
                end
                ST_OUT: if (m_axis_tready) begin
                    r_ovalid <= 1'b0;
                    r_vidx   <= r_vidx + 6'd1;
                    r_rem    <= '0;
                    r_dcnt   <= '0;
                    r_dnum   <= (ANGLE_BITS+6)'(r_vidx + 6'd1) << ANGLE_BITS;
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_valid_only_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_state == ST_OUT)) else $error("valid outside out state");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (6'(m_axis_tdata[36:32]) < r_n)) else $error("index range");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready during output");
`endif
endmodule
